// File: rtl/core/ssbw_pkg.sv
// shared types and constants of the subset-sum window check
package ssbw_pkg;

  localparam int SIZE_W  = 10;
  localparam int TOTAL_W = 11;
  localparam int COUNT_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_SAT = 11'd2047;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 10'd1023;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET      = 2'd1;

  localparam logic [COUNT_W-1:0] TOTAL_COUNT_RST = 10'd1023;
  localparam logic [COUNT_W-1:0] BUDGET_RST      = 10'd0;

  typedef struct packed {
    logic [SIZE_W-1:0] item_size;
    logic              start_new;
  } ssbw_in_t;

  typedef struct packed {
    logic               window_hit;
    logic [COUNT_W-1:0] best_count;
    logic [TOTAL_W-1:0] running_total;
  } ssbw_out_t;

endpackage

// File: rtl/core/subset_sum_bitset_window_check_unit.sv
// top level: sequencer, counters and output register of the subset-sum window check
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall | ssbw_in_t  (item_size, start_new)
//  out_    | output    | out_valid/out_stall | ssbw_out_t (window_hit, best_count, running_total)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (total_count, budget)
//
// the bitset store holds NWORDS = (MAX_TOTAL + WORD_BITS) / WORD_BITS words; after
// acceptance the states S_DIV1, S_DIV2 and S_DIV3 split the size into word and
// bit offsets, then the word unit walks the bitset store top down, one word per
// cycle, after the first walk steps fill the registered read ports
// reset gives an empty bitset (only sum zero) without a clearing pass
// in_stall is high while an item is in work; a stalled result holds the block
// in its last step until the output register frees up
module subset_sum_bitset_window_check_unit
  import ssbw_pkg::*;
#(
  parameter int MAX_TOTAL = 1023,
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ssbw_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ssbw_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data
);

  localparam int NW     = (MAX_TOTAL + WORD_BITS) / WORD_BITS;
  localparam int AW     = NW > 1 ? $clog2(NW) : 1;
  localparam int PART_W = $clog2(WORD_BITS);
  localparam int J_W    = $clog2(NW + 2);
  localparam int IW     = $clog2(NW + 1024) + 2;
  localparam int VW     = $clog2(NW * WORD_BITS + 4096) + 2;
  localparam int K      = 20;
  localparam int RECIP  = (1 << K) / WORD_BITS;
  localparam int PROD_W = SIZE_W + K;

  localparam logic [J_W-1:0] J_TWO  = J_W'(2);
  localparam logic [J_W-1:0] J_NW   = J_W'(NW);
  localparam logic [J_W-1:0] J_LAST = J_W'(NW + 1);
  localparam logic signed [VW-1:0] BASE_TOP = VW'((NW - 1) * WORD_BITS);
  localparam logic signed [VW-1:0] WB_S     = VW'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_DIV3 = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // control state
  logic [2:0]         state_r, state_nxt;
  logic               empty_r, empty_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0] best_r, best_nxt;
  logic [COUNT_W-1:0] items_r, items_nxt;
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic [COUNT_W-1:0] k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;

  // item payload and walk registers
  logic [SIZE_W-1:0]      size_r, size_nxt;
  logic                   fresh_r, fresh_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [SIZE_W-1:0]      whole_r, whole_nxt;
  logic [PART_W:0]        rem_r, rem_nxt;
  logic signed [VW-1:0]   lo_r, lo_nxt;
  logic signed [VW-1:0]   hi_r, hi_nxt;
  logic [J_W-1:0]         j_r, j_nxt;
  logic signed [VW-1:0]   base_r, base_nxt;
  logic                   hit_r, hit_nxt;
  logic [WORD_BITS-1:0]   pa_r, pa_nxt;
  logic                   va_r, a0_r, vb_r, b0_r;
  ssbw_out_t              out_data_r, out_data_nxt;

  logic                   in_acc;
  logic [TOTAL_W:0]       sum_ext;
  logic [TOTAL_W-1:0]     base_total;
  logic [COUNT_W-1:0]     base_items;
  logic [SIZE_W-1:0]      q0;
  logic [TOTAL_W-1:0]     hi_tmp;
  logic signed [IW-1:0]   a_sig, b_sig, w_sig;
  logic                   rd_va, rd_vb;
  logic [WORD_BITS-1:0]   mem_qa, mem_qb, eff_a, eff_b;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WORD_BITS-1:0]   new_word;
  logic                   word_hit;
  logic signed [VW-1:0]   lo_off, hi_off;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // read schedule: port a walks the source words, port b the destination words
  always_comb begin
    a_sig  = IW'(NW - 1) - IW'(whole_r) - IW'(j_r);
    b_sig  = IW'(NW) - IW'(j_r);
    w_sig  = IW'(NW + 1) - IW'(j_r);
    rd_va  = (j_r <= J_NW) && !a_sig[IW-1];
    rd_vb  = (j_r != '0) && (j_r <= J_NW);
    mem_we    = (state_r == S_WALK) && (j_r >= J_TWO);
    mem_waddr = w_sig[AW-1:0];
    // a fresh start reads as the cleared bitset
    eff_a = !va_r ? '0 : (fresh_r ? (a0_r ? WORD_ONE : '0) : mem_qa);
    eff_b = !vb_r ? '0 : (fresh_r ? (b0_r ? WORD_ONE : '0) : mem_qb);
    lo_off = lo_r - base_r;
    hi_off = hi_r - base_r;
  end

  ssbw_bitset_mem #(
    .WORD_BITS(WORD_BITS),
    .DEPTH    (NW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_data  (new_word),
    .rd_addr_a(a_sig[AW-1:0]),
    .rd_addr_b(b_sig[AW-1:0]),
    .rd_data_a(mem_qa),
    .rd_data_b(mem_qb)
  );

  ssbw_word_unit #(
    .WORD_BITS(WORD_BITS),
    .MAX_TOTAL(MAX_TOTAL),
    .VW       (VW)
  ) u_word (
    .src_hi  (pa_r),
    .src_lo  (eff_a),
    .own     (eff_b),
    .part    (rem_r[PART_W-1:0]),
    .is_top  (j_r == J_TWO),
    .lo_off  (lo_off),
    .hi_off  (hi_off),
    .new_word(new_word),
    .word_hit(word_hit)
  );

  always_comb begin
    state_nxt     = state_r;
    empty_nxt     = empty_r;
    total_nxt     = total_r;
    best_nxt      = best_r;
    items_nxt     = items_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    size_nxt      = size_r;
    fresh_nxt     = fresh_r;
    prod_nxt      = prod_r;
    whole_nxt     = whole_r;
    rem_nxt       = rem_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    base_nxt      = base_r;
    hit_nxt       = hit_r;
    pa_nxt        = pa_r;
    out_data_nxt  = out_data_r;
    q0            = '0;
    hi_tmp        = '0;

    base_total = in_data.start_new ? '0 : total_r;
    base_items = in_data.start_new ? '0 : items_r;
    sum_ext    = {1'b0, base_total} + (TOTAL_W + 1)'(in_data.item_size);

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL_COUNT: n_nxt = cfg_data;
        CFG_BUDGET:      k_nxt = cfg_data;
        default:         ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          size_nxt  = in_data.item_size;
          fresh_nxt = in_data.start_new || empty_r;
          empty_nxt = 1'b0;
          total_nxt = sum_ext > {1'b0, TOTAL_SAT} ? TOTAL_SAT : sum_ext[TOTAL_W-1:0];
          items_nxt = base_items < COUNT_SAT ? base_items + 1'b1 : base_items;
          if (in_data.start_new) begin
            best_nxt = '0;
          end
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        prod_nxt  = PROD_W'(size_r) * PROD_W'(RECIP);
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        // reciprocal estimate is exact or one short
        q0        = prod_r[PROD_W-1:K];
        whole_nxt = q0;
        rem_nxt   = (PART_W + 1)'(32'(size_r) - 32'(q0) * WORD_BITS);
        lo_nxt    = VW'(total_r) + VW'(k_r) - VW'(n_r);
        hi_tmp    = total_r;
        if ({1'b0, k_r} < hi_tmp) begin
          hi_tmp = {1'b0, k_r};
        end
        if ({1'b0, n_r} < hi_tmp) begin
          hi_tmp = {1'b0, n_r};
        end
        hi_nxt    = VW'(hi_tmp);
        state_nxt = S_DIV3;
      end
      S_DIV3: begin
        if (rem_r >= (PART_W + 1)'(WORD_BITS)) begin
          whole_nxt = whole_r + 1'b1;
          rem_nxt   = rem_r - (PART_W + 1)'(WORD_BITS);
        end
        j_nxt     = '0;
        base_nxt  = BASE_TOP;
        hit_nxt   = 1'b0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        pa_nxt = eff_a;
        if (j_r >= J_TWO) begin
          hit_nxt  = hit_r | word_hit;
          base_nxt = base_r - WB_S;
        end
        if (j_r == J_LAST) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.window_hit    = hit_r;
          out_data_nxt.best_count    = hit_r ? items_r : best_r;
          out_data_nxt.running_total = total_r;
          if (hit_r) begin
            best_nxt = items_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      empty_r     <= 1'b1;
      total_r     <= '0;
      best_r      <= '0;
      items_r     <= '0;
      n_r         <= TOTAL_COUNT_RST;
      k_r         <= BUDGET_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      empty_r     <= empty_nxt;
      total_r     <= total_nxt;
      best_r      <= best_nxt;
      items_r     <= items_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    fresh_r    <= fresh_nxt;
    prod_r     <= prod_nxt;
    whole_r    <= whole_nxt;
    rem_r      <= rem_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    j_r        <= j_nxt;
    base_r     <= base_nxt;
    hit_r      <= hit_nxt;
    pa_r       <= pa_nxt;
    out_data_r <= out_data_nxt;
    // flags travel alongside the registered read data
    va_r       <= rd_va;
    a0_r       <= a_sig == '0;
    vb_r       <= rd_vb;
    b0_r       <= b_sig == '0;
  end

endmodule

// File: rtl/core/ssbw_bitset_mem.sv
// bitset word store, one write port and two registered read ports
module ssbw_bitset_mem #(
  parameter int WORD_BITS = 64,
  parameter int DEPTH     = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WORD_BITS-1:0]                   wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [WORD_BITS-1:0]                   rd_data_a,
  output logic [WORD_BITS-1:0]                   rd_data_b
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: rtl/core/ssbw_word_unit.sv
// shared word unit: shift-or of one bitset word and window test on the result
module ssbw_word_unit #(
  parameter int WORD_BITS = 64,
  parameter int MAX_TOTAL = 1023,
  parameter int VW        = 18
) (
  input  logic [WORD_BITS-1:0]                 src_hi,
  input  logic [WORD_BITS-1:0]                 src_lo,
  input  logic [WORD_BITS-1:0]                 own,
  input  logic [$clog2(WORD_BITS)-1:0]         part,
  input  logic                                 is_top,
  input  logic signed [VW-1:0]                 lo_off,
  input  logic signed [VW-1:0]                 hi_off,
  output logic [WORD_BITS-1:0]                 new_word,
  output logic                                 word_hit
);

  localparam int PART_W   = $clog2(WORD_BITS);
  localparam int TOP_BITS = MAX_TOTAL % WORD_BITS + 1;
  localparam logic [WORD_BITS-1:0] ONES     = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] TOP_MASK = ONES >> (WORD_BITS - TOP_BITS);
  localparam logic signed [VW-1:0] WB_S     = VW'(WORD_BITS);
  localparam logic signed [VW-1:0] WB_M1_S  = VW'(WORD_BITS - 1);

  logic [2*WORD_BITS-1:0] cat;
  logic [WORD_BITS-1:0]   merged;
  logic [WORD_BITS-1:0]   up_mask;
  logic [WORD_BITS-1:0]   dn_mask;
  logic signed [VW-1:0]   up_amt;

  always_comb begin
    // upper half of the pair shifted left gives src<<part | lower>>(W-part)
    cat      = {src_hi, src_lo} << part;
    merged   = own | cat[2*WORD_BITS-1:WORD_BITS];
    new_word = is_top ? (merged & TOP_MASK) : merged;

    up_amt = WB_M1_S - hi_off;
    if (hi_off < 0) begin
      up_mask = '0;
    end else if (hi_off >= WB_M1_S) begin
      up_mask = ONES;
    end else begin
      up_mask = ONES >> up_amt[PART_W-1:0];
    end

    if (lo_off <= 0) begin
      dn_mask = ONES;
    end else if (lo_off >= WB_S) begin
      dn_mask = '0;
    end else begin
      dn_mask = ONES << lo_off[PART_W-1:0];
    end

    word_hit = |(new_word & up_mask & dn_mask);
  end

endmodule
